FILE: hw/rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// Shared types and constants for the indexed list store.
// ----------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int DEPTH   = 16;
  localparam int ACT_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int STS_W   = 2;
  localparam int COUNT_W = 5;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_READ   = 3'd3,
    ACT_WRITE  = 3'd4
  } action_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SHIFT_UP,
    CELL_SHIFT_DOWN
  } cell_op_e;

  typedef struct packed {
    status_e          status;
    logic [CNT_W-1:0] count_next;
    logic             read_hit;
  } ctrl_res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds an entry, loads a new word or takes a neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_cell (
  input  wire                         clk_i,
  input  wire  ils_pkg::cell_op_e     op_i,
  input  wire  [ils_pkg::VAL_W-1:0]   load_i,
  input  wire  [ils_pkg::VAL_W-1:0]   lower_i,
  input  wire  [ils_pkg::VAL_W-1:0]   upper_i,
  output logic [ils_pkg::VAL_W-1:0]   entry_o
);
  import ils_pkg::*;

  logic [VAL_W-1:0] entry_q;
  logic [VAL_W-1:0] entry_d;

  always_comb begin
    unique case (op_i)
      CELL_LOAD:       entry_d = load_i;
      CELL_SHIFT_UP:   entry_d = lower_i;
      CELL_SHIFT_DOWN: entry_d = upper_i;
      default:         entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

FILE: hw/rtl/ils_ctrl.sv
// ----------------------------------------------------------------------------
// ils_ctrl
// Decodes one action against the count into a status and per-cell commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ils_ctrl (
  input  wire                              accept_i,
  input  wire  [ils_pkg::ACT_W-1:0]        action_i,
  input  wire  [ils_pkg::POS_W-1:0]        position_i,
  input  wire  [ils_pkg::CNT_W-1:0]        count_i,
  output ils_pkg::cell_op_e [ils_pkg::DEPTH-1:0] cell_ops_o,
  output ils_pkg::ctrl_res_t               res_o
);
  import ils_pkg::*;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             in_range;
  logic             ins_range;
  logic             full;
  logic             app_ok;
  logic             ins_ok;
  logic             rem_ok;
  logic             wr_ok;

  assign pos_x     = CMP_W'(position_i);
  assign cnt_x     = CMP_W'(count_i);
  assign in_range  = pos_x < cnt_x;
  assign ins_range = pos_x <= cnt_x;
  assign full      = count_i == CNT_W'(DEPTH);

  always_comb begin
    app_ok         = 1'b0;
    ins_ok         = 1'b0;
    rem_ok         = 1'b0;
    wr_ok          = 1'b0;
    res_o.status   = ST_OK;
    res_o.read_hit = 1'b0;
    unique case (action_e'(action_i))
      ACT_APPEND: begin
        if (full) res_o.status = ST_FULL;
        else      app_ok = 1'b1;
      end
      ACT_INSERT: begin
        if (!ins_range) res_o.status = ST_OOB;
        else if (full)  res_o.status = ST_FULL;
        else            ins_ok = 1'b1;
      end
      ACT_REMOVE: begin
        if (!in_range) res_o.status = ST_OOB;
        else           rem_ok = 1'b1;
      end
      ACT_READ: begin
        if (!in_range) res_o.status = ST_OOB;
        else           res_o.read_hit = 1'b1;
      end
      ACT_WRITE: begin
        if (!in_range) res_o.status = ST_OOB;
        else           wr_ok = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    priority if (app_ok || ins_ok) begin
      res_o.count_next = count_i + CNT_W'(1);
    end else if (rem_ok) begin
      res_o.count_next = count_i - CNT_W'(1);
    end else begin
      res_o.count_next = count_i;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell_op
    localparam logic [CMP_W-1:0] CellIdx   = CMP_W'(i);
    localparam logic [CMP_W-1:0] CellIdxP1 = CMP_W'(i + 1);

    always_comb begin
      cell_ops_o[i] = CELL_HOLD;
      if (accept_i) begin
        priority if (app_ok && CellIdx == cnt_x) begin
          cell_ops_o[i] = CELL_LOAD;
        end else if ((ins_ok || wr_ok) && CellIdx == pos_x) begin
          cell_ops_o[i] = CELL_LOAD;
        end else if (ins_ok && CellIdx > pos_x && CellIdx <= cnt_x) begin
          cell_ops_o[i] = CELL_SHIFT_UP;
        end else if (rem_ok && CellIdx >= pos_x && CellIdxP1 < cnt_x) begin
          cell_ops_o[i] = CELL_SHIFT_DOWN;
        end else begin
          cell_ops_o[i] = CELL_HOLD;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// Ordered list of signed words with append, insert, remove, read, overwrite.
// ----------------------------------------------------------------------------
//
//  port group  dir  handshake                fields
//  ----------  ---  -----------------------  ------------------------------
//  in          in   in_valid_i / in_stall_o  action_i, position_i, value_i
//  out         out  out_valid_o / out_stall_i read_value_o, status_o, count_o
//
//  One word per cycle while no stalled result waits: every cell updates in
//  the accept cycle; the result is in the output register the cycle after.
//  Reset clears the count and the output valid; entries are not cleared.
//  The input stalls only while a result waits and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_store_unit (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_stall_o,
  input  wire  [ils_pkg::ACT_W-1:0]     action_i,
  input  wire  [ils_pkg::POS_W-1:0]     position_i,
  input  wire  signed [ils_pkg::VAL_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire                           out_stall_i,
  output logic signed [ils_pkg::VAL_W-1:0] read_value_o,
  output logic [ils_pkg::STS_W-1:0]     status_o,
  output logic [ils_pkg::COUNT_W-1:0]   count_o
);
  import ils_pkg::*;

  logic                    accept;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        count_d;
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic [VAL_W-1:0]        read_value_q;
  logic [STS_W-1:0]        status_q;
  logic [VAL_W-1:0]        cell_data [DEPTH];
  logic [VAL_W-1:0]        rd_word;
  logic [IDX_W-1:0]        rd_idx;
  cell_op_e [DEPTH-1:0]    cell_ops;
  ctrl_res_t               res;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  ils_ctrl u_ctrl (
    .accept_i   (accept),
    .action_i   (action_i),
    .position_i (position_i),
    .count_i    (count_q),
    .cell_ops_o (cell_ops),
    .res_o      (res)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] lower;
    logic [VAL_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end

    ils_cell u_cell (
      .clk_i   (clk_i),
      .op_i    (cell_ops[i]),
      .load_i  (value_i),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (cell_data[i])
    );
  end

  assign rd_idx  = IDX_W'(CMP_W'(position_i));
  assign rd_word = res.read_hit ? cell_data[rd_idx] : '0;

  always_comb begin
    count_d     = accept ? res.count_next : count_q;
    out_valid_d = accept ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      read_value_q <= rd_word;
      status_q     <= res.status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign count_o      = COUNT_W'(count_q);

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("count above depth");

  a_full_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_APPEND && count_q == CNT_W'(DEPTH)
    |=> status_o == ST_FULL && count_q == $past(count_q))
    else $error("append on full list changed the count");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && action_i == ACT_INSERT && res.status == ST_OK
    |=> count_q == CNT_W'($past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_result_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted word gave no result");

endmodule

`default_nettype wire

FILE: tb/ils_list_checker.sv
// ----------------------------------------------------------------------------
// ils_list_checker
// Watches both word channels of the indexed list store, keeps a shadow copy
// of the list, predicts the result word of every accepted input word and
// compares it field by field with the result words in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ils_list_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  input  wire                              in_stall_i,
  input  wire  [ils_pkg::ACT_W-1:0]        action_i,
  input  wire  [ils_pkg::POS_W-1:0]        position_i,
  input  wire  signed [ils_pkg::VAL_W-1:0] value_i,
  input  wire                              out_valid_i,
  input  wire                              out_stall_i,
  input  wire  signed [ils_pkg::VAL_W-1:0] read_value_i,
  input  wire  [ils_pkg::STS_W-1:0]        status_i,
  input  wire  [ils_pkg::COUNT_W-1:0]      count_i,
  output int                               fail_count_o,
  output int                               pending_o,
  output logic [ils_pkg::CNT_W-1:0]        list_len_o
);
  import ils_pkg::*;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    status_e                 status;
    logic [COUNT_W-1:0]      count;
  } list_result_t;

  list_result_t            expected_results[$];
  logic signed [VAL_W-1:0] shadow_list [DEPTH];
  logic [CNT_W-1:0]        shadow_len = '0;
  int                      mismatch_total = 0;
  int                      pending_words = 0;

  assign fail_count_o = mismatch_total;
  assign pending_o    = pending_words;
  assign list_len_o   = shadow_len;

  task automatic report_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatch_total++;
  endtask

  function automatic list_result_t apply_list_action(input logic [ACT_W-1:0] act,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic signed [VAL_W-1:0] val);
    list_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      ACT_INSERT: begin
        if (pos > shadow_len) begin
          res.status = ST_OOB;
        end else if (shadow_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int i = shadow_len; i > pos; i--) begin
            shadow_list[i] = shadow_list[i-1];
          end
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      ACT_REMOVE: begin
        if (pos >= shadow_len) begin
          res.status = ST_OOB;
        end else begin
          for (int i = pos; i + 1 < shadow_len; i++) begin
            shadow_list[i] = shadow_list[i+1];
          end
          shadow_len--;
        end
      end
      ACT_READ: begin
        if (pos >= shadow_len) res.status = ST_OOB;
        else res.read_value = shadow_list[pos];
      end
      ACT_WRITE: begin
        if (pos >= shadow_len) res.status = ST_OOB;
        else shadow_list[pos] = val;
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(shadow_len);
    return res;
  endfunction

  always @(posedge clk_i) begin
    list_result_t want;
    if (!rst_ni) begin
      shadow_len = '0;
      expected_results.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf(
            "result word with no prediction: value %0d status %0d count %0d",
            read_value_i, status_i, count_i));
        end else begin
          want = expected_results.pop_front();
          if (read_value_i !== want.read_value)
            report_mismatch($sformatf("read_value: expected %0d got %0d",
                                      want.read_value, read_value_i));
          if (status_i !== want.status)
            report_mismatch($sformatf("status: expected %0d got %0d", want.status, status_i));
          if (count_i !== want.count)
            report_mismatch($sformatf("count: expected %0d got %0d", want.count, count_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_list_action(action_i, position_i, value_i));
      end
    end
    pending_words = expected_results.size();
  end

endmodule

FILE: tb/tb_indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// tb_indexed_list_store_unit
// Sends directed list actions (empty and full list, extreme values, every
// action, undefined codes) and then random action sequences that fill and
// drain the list, under three sender/receiver idle mixes and one long
// receiver hold-off. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_indexed_list_store_unit;

  import ils_pkg::*;

  localparam int ACT_CODE_MAX   = 7;
  localparam int RANDOM_PER_PHASE = 634;
  localparam int HOLD_CYCLES    = 80;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [ACT_W-1:0]        action_i;
  logic [POS_W-1:0]        position_i;
  logic signed [VAL_W-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [VAL_W-1:0] read_value_o;
  logic [STS_W-1:0]        status_o;
  logic [COUNT_W-1:0]      count_o;

  int               fail_count;
  int               pending;
  logic [CNT_W-1:0] list_len;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_req      = 1'b0;
  bit hold_taken    = 1'b0;
  int hold_left     = 0;

  indexed_list_store_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

  ils_list_checker u_list_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .action_i     (action_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .read_value_i (read_value_o),
    .status_i     (status_o),
    .count_i      (count_o),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .list_len_o   (list_len)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #5_000_000;
    $display("tb_indexed_list_store_unit NOT OK");
    $finish;
  end

  // receiver: random stall, one long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else begin
        out_stall_i = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // call at a falling edge; returns at the falling edge after the accept
  task automatic send_word(input logic [ACT_W-1:0] act, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    action_i   = act;
    position_i = pos;
    value_i    = val;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  initial begin
    logic [ACT_W-1:0]        act;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] val;
    int                      sent;
    int                      r;
    bit                      fill_mode;

    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = '0;
    position_i = '0;
    value_i    = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_idle_pct = 25;
    stall_pct     = 58;

    // empty list
    send_word(ACT_READ, 0, 0);
    send_word(ACT_REMOVE, 0, 0);
    send_word(ACT_WRITE, 0, 5);
    send_word(ACT_INSERT, 1, 7);
    send_word(ACT_INSERT, 0, 32'sh7FFF_FFFF);
    send_word(ACT_INSERT, 1, 32'sh8000_0000);
    // fill to the top, mixing append and mid-list insert
    for (int i = 2; i < DEPTH; i++) begin
      if (i % 2 == 1) send_word(ACT_APPEND, POS_W'(i), -i);
      else send_word(ACT_INSERT, 1, (i % 4 == 0) ? 32'sh0 : 32'shFFFF_FFFF);
    end
    // full list
    send_word(ACT_APPEND, 0, 1);
    send_word(ACT_INSERT, POS_W'(DEPTH), 1);
    send_word(ACT_INSERT, 31, 1);
    for (int c = int'(ACT_WRITE) + 1; c <= ACT_CODE_MAX; c++) begin
      send_word(ACT_W'(c), 31, 32'sh5A5A_A5A5);
    end
    send_word(ACT_READ, POS_W'(DEPTH - 1), 0);
    send_word(ACT_READ, POS_W'(DEPTH), 0);
    send_word(ACT_WRITE, POS_W'(DEPTH - 1), 32'sh8000_0000);
    send_word(ACT_REMOVE, POS_W'(DEPTH - 1), 0);
    send_word(ACT_REMOVE, 0, 0);

    fill_mode = 1'b1;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 25; stall_pct = 58; end
        1: begin send_idle_pct = 58; stall_pct = 25; end
        default: begin send_idle_pct = 0; stall_pct = 0; hold_req = 1'b1; end
      endcase
      sent = 0;
      while (sent < RANDOM_PER_PHASE) begin
        if (list_len == DEPTH && $urandom_range(3) == 0) fill_mode = 1'b0;
        if (list_len == 0 && $urandom_range(1) == 0) fill_mode = 1'b1;
        if ($urandom_range(49) == 0) fill_mode = ~fill_mode;
        r = $urandom_range(99);
        if (r < 3) act = ACT_W'($urandom_range(int'(ACT_WRITE) + 1, ACT_CODE_MAX));
        else if (fill_mode) begin
          if (r < 30) act = ACT_APPEND;
          else if (r < 60) act = ACT_INSERT;
          else if (r < 70) act = ACT_REMOVE;
          else if (r < 85) act = ACT_READ;
          else act = ACT_WRITE;
        end else begin
          if (r < 13) act = ACT_APPEND;
          else if (r < 23) act = ACT_INSERT;
          else if (r < 58) act = ACT_REMOVE;
          else if (r < 80) act = ACT_READ;
          else act = ACT_WRITE;
        end
        if (act == ACT_APPEND || $urandom_range(9) == 0) pos = POS_W'($urandom_range(31));
        else if (act == ACT_INSERT) pos = POS_W'($urandom_range(list_len));
        else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1));
        else pos = '0;
        case ($urandom_range(7))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7FFF_FFFF;
          2: val = '0;
          3: val = 32'shFFFF_FFFF;
          default: val = $urandom;
        endcase
        send_word(act, pos, val);
        if (act <= ACT_WRITE) sent++;
      end
    end
    in_valid_i = 1'b0;

    wait (pending == 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_indexed_list_store_unit OK");
    end else begin
      $display("tb_indexed_list_store_unit NOT OK");
    end
    $finish;
  end

endmodule
